>>> rtl/core/ssrw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Seven-segment RAM writer package
// Request and write types, action codes, the segment table and the
// reciprocal constants used for the decimal split.
// ----------------------------------------------------------------------------
package ssrw_pkg;

    // Action codes carried by a request.
    localparam logic [1:0] ACT_NUMBER = 2'd0;
    localparam logic [1:0] ACT_DASH   = 2'd1;
    localparam logic [1:0] ACT_INPUT  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Fixed segment patterns (bit 0 = a ... bit 6 = g, bit 7 = dp).
    localparam logic [7:0] DASH_PATTERN  = 8'h40;
    localparam logic [7:0] INPUT_PATTERN = 8'h49;

    // Largest value that can be shown on four digits.
    localparam logic [15:0] VALUE_MAX = 16'd9999;
    localparam int unsigned VAL_W     = 14;
    localparam int unsigned PROD_W    = 27;

    // Reciprocals, exact for every value up to 9999 without correction.
    localparam logic [PROD_W-1:0] RECIP_1000 = 27'd8389;  // shift 23
    localparam logic [PROD_W-1:0] RECIP_100  = 27'd5243;  // shift 19
    localparam logic [PROD_W-1:0] RECIP_10   = 27'd6554;  // shift 16

    // One display request.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] value;
        logic [1:0]  field;
    } req_t;

    // One driver RAM write.
    typedef struct packed {
        logic [6:0] ram_address;
        logic [3:0] nibble;
        logic       last;
    } res_t;

    // Decimal digits of a request, handed to the row serializer.
    typedef struct packed {
        logic [1:0] action;
        logic [1:0] field;
        logic [3:0] thousands;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    // Seven-segment code of one decimal digit; non-digits stay dark.
    function automatic logic [7:0] seg_of_digit(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ssrw_digit_split.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Seven-segment RAM writer: decimal split
// Registers the request, saturates the value and splits it into four
// decimal digits through two pipeline registers.
// ----------------------------------------------------------------------------
module ssrw_digit_split
    import ssrw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire req_t    req,
    output logic         dig_valid,
    input  wire logic    dig_ready,
    output digits_t      dig
);

    logic             a_valid_reg;
    logic [1:0]       a_action_reg;
    logic [1:0]       a_field_reg;
    logic [VAL_W-1:0] a_value_reg;

    logic             b_valid_reg;
    logic [1:0]       b_action_reg;
    logic [1:0]       b_field_reg;
    logic [VAL_W-1:0] b_value_reg;
    logic [3:0]       b_q1000_reg;
    logic [6:0]       b_q100_reg;
    logic [9:0]       b_q10_reg;

    logic             a_ready;
    logic             b_ready;
    logic [VAL_W-1:0] value_sat;
    logic [PROD_W-1:0] prod_1000;
    logic [PROD_W-1:0] prod_100;
    logic [PROD_W-1:0] prod_10;
    logic [6:0]       hund_diff;
    logic [9:0]       tens_diff;
    logic [VAL_W-1:0] unit_diff;

    // Pipeline moves forward when the next stage is empty or draining.
    assign b_ready  = !b_valid_reg || dig_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Values above the four-digit range show as all nines.
    assign value_sat = (req.value > VALUE_MAX) ? VALUE_MAX[VAL_W-1:0]
                                               : req.value[VAL_W-1:0];

    // Stage A: request register. An unused action is dropped here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid && (req.action != ACT_UNUSED);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_action_reg <= req.action;
            a_field_reg  <= req.field;
            a_value_reg  <= value_sat;
        end
    end

    // Quotients by 1000, 100 and 10 via reciprocal multiplication.
    assign prod_1000 = PROD_W'(a_value_reg) * RECIP_1000;
    assign prod_100  = PROD_W'(a_value_reg) * RECIP_100;
    assign prod_10   = PROD_W'(a_value_reg) * RECIP_10;

    // Stage B: quotient register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            b_action_reg <= a_action_reg;
            b_field_reg  <= a_field_reg;
            b_value_reg  <= a_value_reg;
            b_q1000_reg  <= prod_1000[26:23];
            b_q100_reg   <= prod_100[25:19];
            b_q10_reg    <= prod_10[25:16];
        end
    end

    // Each digit is a quotient minus ten times the next coarser one.
    assign hund_diff = b_q100_reg - 7'(b_q1000_reg) * 7'd10;
    assign tens_diff = b_q10_reg - 10'(b_q100_reg) * 10'd10;
    assign unit_diff = b_value_reg - VAL_W'(b_q10_reg) * VAL_W'(10);

    assign dig_valid     = b_valid_reg;
    assign dig.action    = b_action_reg;
    assign dig.field     = b_field_reg;
    assign dig.thousands = b_q1000_reg;
    assign dig.hundreds  = hund_diff[3:0];
    assign dig.tens      = tens_diff[3:0];
    assign dig.units     = unit_diff[3:0];

endmodule
`default_nettype wire

>>> rtl/core/ssrw_row_serializer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Seven-segment RAM writer: row serializer
// Looks up the segment codes of four digits and sends them as eight row
// writes, one per cycle when taken, loading the next request behind the last row.
// ----------------------------------------------------------------------------
module ssrw_row_serializer
    import ssrw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    dig_valid,
    output logic         dig_ready,
    input  wire digits_t dig,
    output logic         out_valid,
    input  wire logic    out_ready,
    output res_t         res
);

    logic            ser_valid_reg;
    logic [2:0]      row_reg;
    logic [1:0]      field_reg;
    logic [3:0][7:0] seg_reg;     // index 3 = thousands, 0 = units
    logic [3:0][7:0] seg_next;

    logic out_fire;
    logic row_last;
    logic load;

    assign row_last  = (row_reg == 3'd7);
    assign out_fire  = ser_valid_reg && out_ready;
    assign load      = dig_valid && (!ser_valid_reg || (out_fire && row_last));
    assign dig_ready = !ser_valid_reg || (out_fire && row_last);

    // Segment codes for the incoming request.
    always_comb
    begin
        unique case (dig.action)
            ACT_DASH:
            begin
                seg_next = {4{DASH_PATTERN}};
            end
            ACT_INPUT:
            begin
                seg_next = {4{INPUT_PATTERN}};
            end
            default:
            begin
                seg_next = {seg_of_digit(dig.thousands), seg_of_digit(dig.hundreds),
                            seg_of_digit(dig.tens), seg_of_digit(dig.units)};
            end
        endcase
    end

    // Row counter and valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            row_reg       <= 3'd0;
        end
        else if (load)
        begin
            ser_valid_reg <= 1'b1;
            row_reg       <= 3'd0;
        end
        else if (out_fire)
        begin
            ser_valid_reg <= !row_last;
            row_reg       <= row_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seg_reg   <= seg_next;
            field_reg <= dig.field;
        end
    end

    // Address is field plus four times the row; nibble is one segment bit per digit.
    assign out_valid       = ser_valid_reg;
    assign res.ram_address = {2'b00, row_reg, field_reg};
    assign res.nibble      = {seg_reg[3][row_reg], seg_reg[2][row_reg],
                              seg_reg[1][row_reg], seg_reg[0][row_reg]};
    assign res.last        = row_last;

endmodule
`default_nettype wire

>>> rtl/core/seven_segment_ram_writer.sv
// An accepted request passes the split's request and quotient registers,
// is loaded into the row serializer, and its eight writes follow on
// consecutive cycles when taken. The serializer loads the next request only
// as its last write is taken; until then it waits in the split pipeline.
// Reset: rst_n clears the valid flags and row counter; no writes pending.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Seven-segment RAM writer
// Turns a four-digit display request into eight LED-driver RAM writes.
// ----------------------------------------------------------------------------
module seven_segment_ram_writer
    import ssrw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire req_t req,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      res
);

    logic    dig_valid;
    logic    dig_ready;
    digits_t dig;

    // Saturation and decimal split.
    ssrw_digit_split u_digit_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req       (req),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .dig       (dig)
    );

    // Segment lookup and row-by-row writes.
    ssrw_row_serializer u_row_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .dig       (dig),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

endmodule
`default_nettype wire

>>> rtl/core/ssrw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Seven-segment RAM writer checker
// Port-level properties of the request and write channels, bound to the
// top level.
// ----------------------------------------------------------------------------
module ssrw_checker
    import ssrw_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire req_t req,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire res_t res
);

    // A waiting request holds its valid and payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(req))
        else $error("ssrw: waiting request changed");

    // Rows of one request come out without gaps.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !res.last |=> out_valid)
        else $error("ssrw: gap inside a request's writes");

    // Each following row sits four addresses higher.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !res.last |=>
            res.ram_address == $past(res.ram_address) + 7'd4)
        else $error("ssrw: row address did not advance by four");

    // The last flag marks segment row seven and the address stays in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (res.ram_address[6:5] == 2'b00)
            && (res.last == (res.ram_address[4:2] == 3'd7)))
        else $error("ssrw: last flag or address range wrong");

    // A stalled write holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res))
        else $error("ssrw: stalled write changed");

endmodule

bind seven_segment_ram_writer ssrw_checker u_ssrw_checker (.*);
`default_nettype wire
